@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, quiet while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check an implication at every rising clock edge, quiet while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/gbl_pkg.sv @@
// ----------------------------------------------------------------------------
// gbl_pkg
// Request codes, field widths and shared types of the gap buffer editor.
// ----------------------------------------------------------------------------
`default_nettype none

package gbl_pkg;

    localparam int REQ_W  = 3;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 9;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LEFT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RIGHT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd4;

    // Status from the pointer unit to the sequencer.
    typedef struct packed {
        logic at_target;   // gap start equals the target
        logic go_right;    // target lies right of the gap start
        logic line_start;  // gap start is zero
        logic line_end;    // gap end is at capacity
        logic gap_empty;   // store is full
    } t_ptr_flags;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

@@ src/gap_buffer_line_editor_core.sv @@
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_core
// Gap buffer holding one line of text, edited one request word at a time.
//
//   channel   handshake              payload
//   -------   --------------------   ----------------------------------------
//   request   start / busy           i_req_type, i_char_in, i_target_pos
//   result    o_valid (1-cycle)      o_ok, o_cursor, o_length
//
// A request word is taken at a rising edge with start high and busy low.
// Insert, delete and refused requests go from idle straight to the done state.
// Left, right and gap moves pass through a read and a write state for each
// byte shifted: each shift reads one byte, then writes it once the registered
// read data is back; a last read state stops at the target before done.
// Reset (synchronous, active low) empties the line; store contents stay.
// Each result word shows for one cycle with o_valid; nothing holds it off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gap_buffer_line_editor_core
    import gbl_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [CHAR_W-1:0] i_char_in,
    input  wire logic [POS_W-1:0]  i_target_pos,
    output logic                   o_valid,
    output logic                   o_ok,
    output logic      [POS_W-1:0]  o_cursor,
    output logic      [POS_W-1:0]  o_length
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    // Wide enough for target + gap and for the output arithmetic.
    localparam int LW = ((PW > POS_W) ? PW : POS_W) + 1;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    t_state        r_state, n_state;
    logic [PW-1:0] r_gap_start, n_gap_start;
    logic [PW-1:0] r_gap_end, n_gap_end;
    logic [PW-1:0] r_target, n_target;
    logic          r_ok, n_ok;

    // Pointer unit results
    logic [PW-1:0] gs_inc, gs_dec, ge_inc, ge_dec;
    logic [AW-1:0] rd_addr, wr_addr;
    t_ptr_flags    flags;

    // Store port controls
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [CHAR_W-1:0] mem_rdata;

    // Move request checks
    logic [LW-1:0] gap_l;
    logic [LW-1:0] tgt_l;
    logic [LW-1:0] span_l;
    logic          move_ok;

    // Output arithmetic
    logic [LW-1:0] cursor_l;
    logic [LW-1:0] length_l;

    gbl_ptr_unit #(
        .CAPACITY (CAPACITY)
    ) u_ptr (
        .i_gap_start (r_gap_start),
        .i_gap_end   (r_gap_end),
        .i_target    (r_target),
        .o_gs_inc    (gs_inc),
        .o_gs_dec    (gs_dec),
        .o_ge_inc    (ge_inc),
        .o_ge_dec    (ge_dec),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_flags     (flags)
    );

    gbl_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    // Gap move is legal when the target differs from the cursor and the
    // bytes after the gap still fit behind it.
    assign gap_l   = LW'(r_gap_end) - LW'(r_gap_start);
    assign tgt_l   = LW'(i_target_pos);
    assign span_l  = tgt_l + gap_l;
    assign move_ok = (tgt_l != LW'(r_gap_start)) && (span_l <= CAP_L);

    always_comb begin
        n_state     = r_state;
        n_gap_start = r_gap_start;
        n_gap_end   = r_gap_end;
        n_target    = r_target;
        n_ok        = r_ok;
        mem_we      = 1'b0;
        mem_waddr   = wr_addr;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                    unique case (i_req_type)
                        REQ_INSERT: begin
                            // Drop the byte into the gap and advance the cursor.
                            if (!flags.gap_empty) begin
                                mem_we      = 1'b1;
                                mem_waddr   = r_gap_start[AW-1:0];
                                mem_wdata   = i_char_in;
                                n_gap_start = gs_inc;
                                n_ok        = 1'b1;
                            end
                        end
                        REQ_DELETE: begin
                            if (!flags.line_start) begin
                                n_gap_start = gs_dec;
                                n_ok        = 1'b1;
                            end
                        end
                        REQ_LEFT: begin
                            if (!flags.line_start) begin
                                n_target = gs_dec;
                                n_ok     = 1'b1;
                                n_state  = S_READ;
                            end
                        end
                        REQ_RIGHT: begin
                            if (!flags.line_end) begin
                                n_target = gs_inc;
                                n_ok     = 1'b1;
                                n_state  = S_READ;
                            end
                        end
                        REQ_MOVE: begin
                            if (move_ok) begin
                                n_target = tgt_l[PW-1:0];
                                n_ok     = 1'b1;
                                n_state  = S_READ;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                // Stop at the target, else fetch the next byte to carry over.
                if (flags.at_target) begin
                    n_state = S_DONE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                // Land the fetched byte on the far side and slide the gap.
                mem_we    = 1'b1;
                mem_waddr = wr_addr;
                mem_wdata = mem_rdata;
                if (flags.go_right) begin
                    n_gap_start = gs_inc;
                    n_gap_end   = ge_inc;
                end else begin
                    n_gap_start = gs_dec;
                    n_gap_end   = ge_dec;
                end
                n_state = S_READ;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gap_start <= '0;
            r_gap_end   <= CAP_P;
            r_ok        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gap_start <= n_gap_start;
            r_gap_end   <= n_gap_end;
            r_ok        <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
    end

    // Result word: pointers are final while in the done state.
    assign cursor_l = LW'(r_gap_start);
    assign length_l = LW'(r_gap_start) + CAP_L - LW'(r_gap_end);

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign o_ok     = r_ok;
    assign o_cursor = cursor_l[POS_W-1:0];
    assign o_length = length_l[POS_W-1:0];

    `ASSERT_CLK(a_gap_order, (r_gap_start <= r_gap_end) && (r_gap_end <= CAP_P), "bad gap order")
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `ASSERT_NEXT(a_valid_pulse, o_valid, !o_valid, "result strobe held past one cycle")
    `ASSERT_NEXT(a_gap_size, r_state == S_WRITE, gap_l == $past(gap_l), "gap size changed")
    `ASSERT_IMPL(a_idle_hold, (r_state == S_IDLE) && !start, n_state == S_IDLE, "idle not held")

endmodule

`default_nettype wire

@@ src/gbl_store.sv @@
// ----------------------------------------------------------------------------
// gbl_store
// Text store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbl_store
    import gbl_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [$clog2(CAPACITY)-1:0] i_waddr,
    input  wire logic [CHAR_W-1:0]           i_wdata,
    input  wire logic                        i_re,
    input  wire logic [$clog2(CAPACITY)-1:0] i_raddr,
    output logic      [CHAR_W-1:0]           o_rdata
);

    logic [CHAR_W-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/gbl_ptr_unit.sv @@
// ----------------------------------------------------------------------------
// gbl_ptr_unit
// Shared step and compare unit for the gap pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module gbl_ptr_unit
    import gbl_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic [$clog2(CAPACITY+1)-1:0] i_gap_start,
    input  wire logic [$clog2(CAPACITY+1)-1:0] i_gap_end,
    input  wire logic [$clog2(CAPACITY+1)-1:0] i_target,
    output logic      [$clog2(CAPACITY+1)-1:0] o_gs_inc,
    output logic      [$clog2(CAPACITY+1)-1:0] o_gs_dec,
    output logic      [$clog2(CAPACITY+1)-1:0] o_ge_inc,
    output logic      [$clog2(CAPACITY+1)-1:0] o_ge_dec,
    output logic      [$clog2(CAPACITY)-1:0]   o_rd_addr,
    output logic      [$clog2(CAPACITY)-1:0]   o_wr_addr,
    output t_ptr_flags                         o_flags
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [PW-1:0] ONE_P = PW'(1);

    logic [PW-1:0] rd_pos;
    logic [PW-1:0] wr_pos;

    assign o_gs_inc = i_gap_start + ONE_P;
    assign o_gs_dec = i_gap_start - ONE_P;
    assign o_ge_inc = i_gap_end + ONE_P;
    assign o_ge_dec = i_gap_end - ONE_P;

    assign o_flags.at_target  = (i_target == i_gap_start);
    assign o_flags.go_right   = (i_target > i_gap_start);
    assign o_flags.line_start = (i_gap_start == '0);
    assign o_flags.line_end   = (i_gap_end == CAP_P);
    assign o_flags.gap_empty  = (i_gap_start == i_gap_end);

    // Right: pull the byte after the gap to the gap start.
    // Left: push the byte before the gap to the gap end.
    assign rd_pos = o_flags.go_right ? i_gap_end   : o_gs_dec;
    assign wr_pos = o_flags.go_right ? i_gap_start : o_ge_dec;

    assign o_rd_addr = rd_pos[AW-1:0];
    assign o_wr_addr = wr_pos[AW-1:0];

endmodule

`default_nettype wire
